@@ rtl/scl_pkg.sv @@
// Shared constants and controller/datapath interface types for the sector cache.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int ENTRIES      = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int ADDR_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W       = $clog2(ENTRIES + 1);
    localparam int ID_W         = 32;
    localparam int DATA_W       = 64;
    localparam int STAMP_W      = 32;
    localparam int CNT_W        = 32;
    localparam int PCT_W        = 7;
    localparam int QBIT_W       = 3;
    localparam int NUM_W        = CNT_W + 8;
    localparam int DEN_W        = CNT_W + 1;
    localparam int PCT_SCALE    = 100;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
        logic div_load;
        logic div_sel_miss;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_last;
    } t_sts;

endpackage

@@ rtl/scl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/scl_ctrl.sv @@
// Sequencing state machine for lookup, update and percentage division.
`timescale 1ns / 1ps

module scl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  scl_pkg::t_sts i_sts,
    output scl_pkg::t_cmd o_cmd
);
    import scl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_LOADH,
        S_DIVH,
        S_LOADM,
        S_DIVM,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd = '0;
        case (r_state)
            S_IDLE:   cmd.capture = i_in_valid;
            S_SCAN:   cmd.scan = 1'b1;
            S_COMMIT: cmd.commit = 1'b1;
            S_LOADH:  cmd.div_load = 1'b1;
            S_DIVH:   cmd.div_step = 1'b1;
            S_LOADM: begin
                cmd.div_load     = 1'b1;
                cmd.div_sel_miss = 1'b1;
            end
            S_DIVM:   cmd.div_step = 1'b1;
            S_DONE:   cmd.out_load = !r_out_valid || i_out_ready;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_SCAN;
                S_SCAN:   if (i_sts.scan_done) r_state <= S_COMMIT;
                S_COMMIT: r_state <= S_LOADH;
                S_LOADH:  r_state <= S_DIVH;
                S_DIVH:   if (i_sts.div_last) r_state <= S_LOADM;
                S_LOADM:  r_state <= S_DIVM;
                S_DIVM:   if (i_sts.div_last) r_state <= S_DONE;
                S_DONE:   if (cmd.out_load) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

@@ rtl/scl_dp.sv @@
// Datapath: entry memories, scan compare, counters and the percentage divider.
`timescale 1ns / 1ps

module scl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scl_pkg::t_cmd                     i_cmd,
    output scl_pkg::t_sts                     o_sts,
    input  logic                              i_action,
    input  logic [scl_pkg::ID_W-1:0]          i_sector_id,
    input  logic [scl_pkg::DATA_W-1:0]        i_write_data,
    output logic                              o_found,
    output logic [scl_pkg::DATA_W-1:0]        o_read_data,
    output logic [scl_pkg::CNT_W-1:0]         o_hit_count,
    output logic [scl_pkg::CNT_W-1:0]         o_miss_count,
    output logic [scl_pkg::PCT_W-1:0]         o_hit_percent,
    output logic [scl_pkg::PCT_W-1:0]         o_miss_percent
);
    import scl_pkg::*;

    logic [FILL_W-1:0]       r_fill;
    logic [STAMP_W-1:0]      r_clock;
    logic [CNT_W-1:0]        r_hits;
    logic [CNT_W-1:0]        r_misses;

    logic                    r_wr;
    logic [ID_W-1:0]         r_id;
    logic [PAYLOAD_BITS-1:0] r_data;
    logic [STAMP_W-1:0]      r_stamp;

    logic [FILL_W-1:0]       r_ptr;
    logic                    r_cmp_vld;
    logic [ADDR_W-1:0]       r_cmp_idx;
    logic                    r_hit;
    logic [ADDR_W-1:0]       r_pos;
    logic [STAMP_W-1:0]      r_min;
    logic [ADDR_W-1:0]       r_old;

    logic [DATA_W-1:0]       r_rd;
    logic [NUM_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_dsh;
    logic                    r_den_nz;
    logic [QBIT_W-1:0]       r_bit;
    logic [PCT_W-1:0]        r_q;
    logic [PCT_W-1:0]        r_hp;

    logic                    r_o_found;
    logic [DATA_W-1:0]       r_o_rd;
    logic [CNT_W-1:0]        r_o_hits;
    logic [CNT_W-1:0]        r_o_misses;
    logic [PCT_W-1:0]        r_o_hp;
    logic [PCT_W-1:0]        r_o_mp;

    logic [ID_W-1:0]         id_q;
    logic [STAMP_W-1:0]      stamp_q;
    logic [PAYLOAD_BITS-1:0] pay_q;
    logic [ADDR_W-1:0]       scan_addr;
    logic [ADDR_W-1:0]       slot;
    logic                    full;
    logic                    we_entry;
    logic                    we_stamp;
    logic [CNT_W-1:0]        div_src;
    logic [NUM_W-1:0]        num_src;
    logic [DEN_W-1:0]        den_sum;
    logic                    ge;

    assign scan_addr = r_ptr[ADDR_W-1:0];
    assign full      = (r_fill == FILL_W'(ENTRIES));
    assign slot      = r_hit ? r_pos : (full ? r_old : r_fill[ADDR_W-1:0]);
    assign we_entry  = i_cmd.commit && (r_wr == ACT_WRITE);
    assign we_stamp  = i_cmd.commit && ((r_wr == ACT_WRITE) || r_hit);

    // Multiply by one hundred as 64x + 32x + 4x.
    assign div_src = i_cmd.div_sel_miss ? r_misses : r_hits;
    assign num_src = (NUM_W'(div_src) << 6) + (NUM_W'(div_src) << 5)
                   + (NUM_W'(div_src) << 2);
    assign den_sum = DEN_W'(r_hits) + DEN_W'(r_misses);
    assign ge      = r_den_nz && (r_rem >= r_dsh);

    scl_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (we_entry),
        .i_waddr (slot),
        .i_wdata (r_id),
        .i_raddr (scan_addr),
        .o_rdata (id_q)
    );

    scl_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (we_stamp),
        .i_waddr (slot),
        .i_wdata (r_stamp),
        .i_raddr (scan_addr),
        .o_rdata (stamp_q)
    );

    scl_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (we_entry),
        .i_waddr (slot),
        .i_wdata (r_data),
        .i_raddr (r_pos),
        .o_rdata (pay_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_clock   <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_clock   <= r_clock + 1'b1;
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= (r_ptr != r_fill);
            end
            if (i_cmd.commit) begin
                if (r_wr == ACT_WRITE) begin
                    if (!r_hit && !full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end else if (r_hit) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end else if (r_misses != '1) begin
                    r_misses <= r_misses + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wr    <= i_action;
            r_id    <= i_sector_id;
            r_data  <= i_write_data[PAYLOAD_BITS-1:0];
            r_stamp <= r_clock;
            r_ptr   <= '0;
            r_hit   <= 1'b0;
            r_pos   <= '0;
            r_old   <= '0;
            r_min   <= '0;
        end
        if (i_cmd.scan && (r_ptr != r_fill)) begin
            r_ptr     <= r_ptr + 1'b1;
            r_cmp_idx <= scan_addr;
        end
        if (r_cmp_vld) begin
            if (!r_hit && (id_q == r_id)) begin
                r_hit <= 1'b1;
                r_pos <= r_cmp_idx;
            end
            if ((r_cmp_idx == '0) || (stamp_q < r_min)) begin
                r_min <= stamp_q;
                r_old <= r_cmp_idx;
            end
        end
        if (i_cmd.div_load) begin
            r_rem    <= num_src;
            r_dsh    <= NUM_W'(den_sum) << (PCT_W - 1);
            r_den_nz <= (den_sum != '0);
            r_bit    <= QBIT_W'(PCT_W - 1);
            r_q      <= '0;
            if (i_cmd.div_sel_miss) begin
                r_hp <= r_q;
            end else begin
                r_rd <= ((r_wr == ACT_READ) && r_hit) ? DATA_W'(pay_q) : '0;
            end
        end
        if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[PCT_W-2:0], ge};
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_found  <= r_hit;
            r_o_rd     <= r_rd;
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
            r_o_hp     <= r_hp;
            r_o_mp     <= r_q;
        end
    end

    assign o_sts.scan_done = (r_ptr == r_fill) && !r_cmp_vld;
    assign o_sts.div_last  = (r_bit == '0);

    assign o_found        = r_o_found;
    assign o_read_data    = r_o_rd;
    assign o_hit_count    = r_o_hits;
    assign o_miss_count   = r_o_misses;
    assign o_hit_percent  = r_o_hp;
    assign o_miss_percent = r_o_mp;

endmodule

@@ rtl/sector_cache_lru.sv @@
// Top level of the fully associative sector cache with LRU replacement.
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_action, i_sector_id, i_write_data
//  out      output     o_out_valid / i_out_ready  o_found, o_read_data, o_hit_count,
//                                                 o_miss_count, o_hit_percent,
//                                                 o_miss_percent
//
// Each transfer passes through taking the item, the pipelined tag and stamp scan, the commit,
// a load and seven steps for each percentage quotient, and a load of the result.
// Reset is synchronous and active low; it empties the cache and clears all counters.
// A new item is taken while the previous result waits in the output register; a
// stalled output holds the next item only in its final state.
`timescale 1ns / 1ps

module sector_cache_lru (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_action,
    input  logic [scl_pkg::ID_W-1:0]   i_sector_id,
    input  logic [scl_pkg::DATA_W-1:0] i_write_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [scl_pkg::DATA_W-1:0] o_read_data,
    output logic [scl_pkg::CNT_W-1:0]  o_hit_count,
    output logic [scl_pkg::CNT_W-1:0]  o_miss_count,
    output logic [scl_pkg::PCT_W-1:0]  o_hit_percent,
    output logic [scl_pkg::PCT_W-1:0]  o_miss_percent
);
    import scl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    scl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    scl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_sector_id    (i_sector_id),
        .i_write_data   (i_write_data),
        .o_found        (o_found),
        .o_read_data    (o_read_data),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count),
        .o_hit_percent  (o_hit_percent),
        .o_miss_percent (o_miss_percent)
    );

endmodule

@@ tb/sector_cache_lru_checker.sv @@
// Checker for the sector cache: predicts each access result and compares it.
`timescale 1ns / 1ps

module sector_cache_lru_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_action,
    input  logic [scl_pkg::ID_W-1:0]   i_sector_id,
    input  logic [scl_pkg::DATA_W-1:0] i_write_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_found,
    input  logic [scl_pkg::DATA_W-1:0] i_read_data,
    input  logic [scl_pkg::CNT_W-1:0]  i_hit_count,
    input  logic [scl_pkg::CNT_W-1:0]  i_miss_count,
    input  logic [scl_pkg::PCT_W-1:0]  i_hit_percent,
    input  logic [scl_pkg::PCT_W-1:0]  i_miss_percent,
    output int                         o_fail_count,
    output int                         o_pending
);

    import scl_pkg::*;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
        logic [PCT_W-1:0]  hit_pct;
        logic [PCT_W-1:0]  miss_pct;
    } t_access_result;

    localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

    logic [FILL_W-1:0]  fill;
    logic [ID_W-1:0]    tag_ids [ENTRIES];
    logic [DATA_W-1:0]  tag_data [ENTRIES];
    logic [STAMP_W-1:0] tag_stamps [ENTRIES];
    logic [STAMP_W-1:0] access_clock;
    logic [CNT_W-1:0]   read_hits;
    logic [CNT_W-1:0]   read_misses;

    t_access_result result_q[$];
    t_access_result seen;
    t_access_result want;
    int             mismatches = 0;

    function automatic t_access_result cache_access(logic act, logic [ID_W-1:0] id,
                                                    logic [DATA_W-1:0] data);
        int                 pos;
        int                 slot;
        logic [STAMP_W-1:0] stamp;
        logic [63:0]        total;
        t_access_result     r;
        pos = -1;
        stamp = access_clock;
        access_clock = access_clock + 1'b1;
        r = '0;
        for (int k = 0; k < fill; k++) begin
            if (pos < 0 && tag_ids[k] == id) begin
                pos = k;
            end
        end
        if (act == ACT_WRITE) begin
            if (pos >= 0) begin
                slot = pos;
            end else if (fill < ENTRIES) begin
                slot = int'(fill);
                fill = fill + 1'b1;
            end else begin
                slot = 0;
                for (int k = 1; k < fill; k++) begin
                    if (tag_stamps[k] < tag_stamps[slot]) begin
                        slot = k;
                    end
                end
            end
            tag_ids[slot] = id;
            tag_data[slot] = data & PAYLOAD_MASK;
            tag_stamps[slot] = stamp;
        end else if (pos >= 0) begin
            r.read_data = tag_data[pos];
            tag_stamps[pos] = stamp;
            if (read_hits != '1) begin
                read_hits = read_hits + 1'b1;
            end
        end else if (read_misses != '1) begin
            read_misses = read_misses + 1'b1;
        end
        total = 64'(read_hits) + 64'(read_misses);
        if (total != 0) begin
            r.hit_pct = PCT_W'((64'(read_hits) * PCT_SCALE) / total);
            r.miss_pct = PCT_W'((64'(read_misses) * PCT_SCALE) / total);
        end
        r.found = (pos >= 0);
        r.hits = read_hits;
        r.misses = read_misses;
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = '0;
            access_clock = '0;
            read_hits = '0;
            read_misses = '0;
            for (int k = 0; k < ENTRIES; k++) begin
                tag_ids[k] = '0;
                tag_data[k] = '0;
                tag_stamps[k] = '0;
            end
            result_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen = '{i_found, i_read_data, i_hit_count, i_miss_count,
                         i_hit_percent, i_miss_percent};
                if (result_q.size() == 0) begin
                    $error("Result transfer arrived with no access outstanding.");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("found", 64'(want.found), 64'(seen.found));
                    compare_field("read_data", want.read_data, seen.read_data);
                    compare_field("hit_count", 64'(want.hits), 64'(seen.hits));
                    compare_field("miss_count", 64'(want.misses), 64'(seen.misses));
                    compare_field("hit_percent", 64'(want.hit_pct), 64'(seen.hit_pct));
                    compare_field("miss_percent", 64'(want.miss_pct), 64'(seen.miss_pct));
                end
            end
            if (i_in_valid && i_in_ready) begin
                result_q.push_back(cache_access(i_action, i_sector_id, i_write_data));
            end
        end
        o_pending <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/sector_cache_lru_tb.sv @@
// Testbench top for the sector cache: stimulus, handshake pacing and the verdict.
`timescale 1ns / 1ps

module sector_cache_lru_tb;

    import scl_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 357;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = ACT_READ;
    logic [ID_W-1:0]    i_sector_id = '0;
    logic [DATA_W-1:0]  i_write_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_found;
    logic [DATA_W-1:0]  o_read_data;
    logic [CNT_W-1:0]   o_hit_count;
    logic [CNT_W-1:0]   o_miss_count;
    logic [PCT_W-1:0]   o_hit_percent;
    logic [PCT_W-1:0]   o_miss_percent;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    sector_cache_lru u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_sector_id    (i_sector_id),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_read_data    (o_read_data),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count),
        .o_hit_percent  (o_hit_percent),
        .o_miss_percent (o_miss_percent)
    );

    sector_cache_lru_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_sector_id    (i_sector_id),
        .i_write_data   (i_write_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_found        (o_found),
        .i_read_data    (o_read_data),
        .i_hit_count    (o_hit_count),
        .i_miss_count   (o_miss_count),
        .i_hit_percent  (o_hit_percent),
        .i_miss_percent (o_miss_percent),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A hold-off request blocks the result channel for a long run of cycles.
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_access(input logic act, input logic [ID_W-1:0] id,
                               input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_sector_id <= id;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_random(input int items, input int idle, input int stall);
        logic [ID_W-1:0] pool [32];
        int              pool_size;
        logic [ID_W-1:0] id;
        logic            act;
        idle_pct = idle;
        stall_pct = stall;
        pool_size = $urandom_range(28, 6);
        for (int k = 0; k < 32; k++) begin
            pool[k] = $urandom;
        end
        for (int n = 0; n < items; n++) begin
            act = ($urandom_range(99) < 45) ? ACT_WRITE : ACT_READ;
            id = ($urandom_range(19) == 0) ? ID_W'($urandom)
                                           : pool[5'($urandom_range(pool_size - 1))];
            send_access(act, id, {$urandom, $urandom});
        end
        drain_results();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Writes before any read leave both percentages at zero.
        send_access(ACT_WRITE, 32'h0000_0000, {DATA_W{1'b1}});
        send_access(ACT_READ, 32'hFFFF_FFFF, {DATA_W{1'b1}});
        send_access(ACT_READ, 32'h0000_0000, '0);
        send_access(ACT_WRITE, 32'hFFFF_FFFF, '0);
        send_access(ACT_WRITE, 32'h0000_0000, 64'hA5A5_5A5A_C3C3_3C3C);
        for (int k = 0; k < 14; k++) begin
            send_access(ACT_WRITE, 32'h0000_1000 + k, {$urandom, $urandom});
        end
        // The newest entry sits in the last slot of a full cache.
        send_access(ACT_READ, 32'h0000_100D, '0);
        send_access(ACT_WRITE, 32'h0000_ABCD, 64'h0123_4567_89AB_CDEF);
        send_access(ACT_READ, 32'hFFFF_FFFF, '0);
        send_access(ACT_READ, 32'h0000_0000, '0);
        drain_results();

        // The result channel is held off while the sender keeps offering items.
        hold_requests = hold_requests + 1;
        run_random(PHASE_ITEMS, 0, 0);
        run_random(PHASE_ITEMS, 51, 0);
        run_random(PHASE_ITEMS, 0, 51);
        run_random(PHASE_ITEMS, 28, 28);

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/scl_pkg.sv
rtl/scl_ram.sv
rtl/scl_ctrl.sv
rtl/scl_dp.sv
rtl/sector_cache_lru.sv
tb/sector_cache_lru_checker.sv
tb/sector_cache_lru_tb.sv
